// File: rtl/core/joint_pd_servo_with_limits_unit_defines.svh
// Assertion macros for the joint PD servo unit.
// Used by the port checker; no other dependencies.
`ifndef JOINT_PD_SERVO_WITH_LIMITS_UNIT_DEFINES_SVH
`define JOINT_PD_SERVO_WITH_LIMITS_UNIT_DEFINES_SVH

// Same-cycle implication, disabled while reset is active.
`define JPS_CHECK(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is active.
`define JPS_CHECK_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: rtl/core/jps_pkg.sv
// Shared types, constants and gain tables of the joint PD servo unit.
// No dependencies; used by every module of the block except jps_ram.
`default_nettype none

package jps_pkg;

    localparam int JOINTS   = 17;
    localparam int JOINT_W  = 5;
    localparam int ANGLE_W  = 16;
    localparam int ERR_W    = 17;
    localparam int LIM_W    = 2 * ANGLE_W;
    localparam int RAM_AW   = (JOINTS > 1) ? $clog2(JOINTS) : 1;

    localparam logic KIND_CTRL = 1'b0;
    localparam logic KIND_LOAD = 1'b1;

    typedef logic        [JOINT_W-1:0] t_joint;
    typedef logic signed [ANGLE_W-1:0] t_angle;
    typedef logic signed [ERR_W-1:0]   t_err;
    typedef logic signed [ERR_W:0]     t_diff;
    typedef logic signed [13:0]        t_kp;
    typedef logic signed [18:0]        t_kdr;
    typedef logic signed [30:0]        t_pkp;
    typedef logic signed [36:0]        t_pkd;
    typedef logic signed [37:0]        t_sum;
    typedef logic signed [25:0]        t_quot;
    typedef logic signed [15:0]        t_accel;

    localparam t_angle ANGLE_MIN = 16'sh8000;
    localparam t_angle ANGLE_MAX = 16'sh7FFF;
    localparam t_accel ACC_MAX   = 16'sd1280;
    localparam t_sum   ROUND_HALF = 38'sd2048;
    localparam int     FRAC_SHIFT = 12;

    typedef struct packed {
        t_joint joint;
        t_err   err;
        t_err   prev;
    } t_s1_item;

    function automatic t_kp kp_q8(input t_joint j);
        t_kp k;
        case (j)
            5'd5, 5'd12: k = 14'sd7168;
            5'd6, 5'd13: k = 14'sd512;
            default:     k = 14'sd768;
        endcase
        return k;
    endfunction

    function automatic t_kdr kdr_q8(input t_joint j);
        t_kdr k;
        case (j)
            5'd0, 5'd1, 5'd2, 5'd10:          k = 19'sd38400;
            5'd3:                             k = 19'sd42240;
            5'd4, 5'd12:                      k = 19'sd140800;
            5'd5, 5'd13:                      k = 19'sd24320;
            5'd6:                             k = 19'sd57600;
            5'd7, 5'd8, 5'd9:                 k = 19'sd1280;
            5'd14, 5'd15, 5'd16:              k = 19'sd1280;
            5'd11:                            k = 19'sd37120;
            default:                          k = 19'sd0;
        endcase
        return k;
    endfunction

    function automatic t_accel acc_min(input t_joint j);
        t_accel a;
        case (j)
            5'd7, 5'd8, 5'd9, 5'd14, 5'd15, 5'd16: a = -16'sd5120;
            default:                               a = -16'sd1280;
        endcase
        return a;
    endfunction

endpackage

`default_nettype wire

// File: rtl/core/jps_ram.sv
// Generic simple dual-port RAM with one write port and a registered read port.
// No dependencies.
`default_nettype none

module jps_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 17
) (
    input  wire logic                             i_clk,
    input  wire logic                             i_we,
    input  wire logic [$clog2(DEPTH)-1:0]         i_waddr,
    input  wire logic [WIDTH-1:0]                 i_wdata,
    input  wire logic                             i_re,
    input  wire logic [$clog2(DEPTH)-1:0]         i_raddr,
    output logic      [WIDTH-1:0]                 o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            o_rdata <= r_mem[i_raddr];
        end
    end

endmodule

`default_nettype wire

// File: rtl/core/jps_store.sv
// Per-joint state: limit and error memories, valid bits, error forwarding,
// and the clamp/error stage. Depends on jps_pkg and jps_ram.
`default_nettype none

module jps_store (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_in_valid,
    output logic                   o_in_ready,
    input  wire logic              i_kind,
    input  wire jps_pkg::t_joint   i_joint,
    input  wire jps_pkg::t_angle   i_desired_angle,
    input  wire jps_pkg::t_angle   i_measured_angle,
    input  wire jps_pkg::t_angle   i_limit_lower,
    input  wire jps_pkg::t_angle   i_limit_upper,
    input  wire logic              i_s2_ready,
    output logic                   o_s1_valid,
    output jps_pkg::t_s1_item      o_s1
);

    logic                        w_acc;
    logic                        w_in_range;
    logic                        w_ctl_acc;
    logic                        w_ld_acc;
    logic                        w_s1_adv;
    logic [jps_pkg::LIM_W-1:0]   w_lim_rd;
    logic [jps_pkg::ERR_W-1:0]   w_err_rd;
    jps_pkg::t_angle             w_lo;
    jps_pkg::t_angle             w_up;
    jps_pkg::t_angle             w_des;
    jps_pkg::t_err               w_err;
    jps_pkg::t_err               w_prev;

    logic                        r_s1_v;
    jps_pkg::t_joint             r_s1_joint;
    jps_pkg::t_angle             r_s1_des;
    jps_pkg::t_angle             r_s1_meas;
    logic                        r_s1_lv;
    logic                        r_s1_ev;
    logic                        r_s1_fwd;
    jps_pkg::t_err               r_fwd_err;
    logic [jps_pkg::JOINTS-1:0]  r_err_vld;
    logic [jps_pkg::JOINTS-1:0]  r_lim_vld;

    assign o_in_ready = !r_s1_v || i_s2_ready;
    assign w_acc      = i_in_valid && o_in_ready;
    assign w_in_range = i_joint < jps_pkg::JOINT_W'(jps_pkg::JOINTS);
    assign w_ctl_acc  = w_acc && w_in_range && (i_kind == jps_pkg::KIND_CTRL);
    assign w_ld_acc   = w_acc && w_in_range && (i_kind == jps_pkg::KIND_LOAD);
    assign w_s1_adv   = r_s1_v && i_s2_ready;

    jps_ram #(
        .WIDTH (jps_pkg::LIM_W),
        .DEPTH (jps_pkg::JOINTS)
    ) u_lim_ram (
        .i_clk   (i_clk),
        .i_we    (w_ld_acc),
        .i_waddr (i_joint[jps_pkg::RAM_AW-1:0]),
        .i_wdata ({i_limit_lower, i_limit_upper}),
        .i_re    (w_ctl_acc),
        .i_raddr (i_joint[jps_pkg::RAM_AW-1:0]),
        .o_rdata (w_lim_rd)
    );

    jps_ram #(
        .WIDTH (jps_pkg::ERR_W),
        .DEPTH (jps_pkg::JOINTS)
    ) u_err_ram (
        .i_clk   (i_clk),
        .i_we    (w_s1_adv),
        .i_waddr (r_s1_joint[jps_pkg::RAM_AW-1:0]),
        .i_wdata (w_err),
        .i_re    (w_ctl_acc),
        .i_raddr (i_joint[jps_pkg::RAM_AW-1:0]),
        .o_rdata (w_err_rd)
    );

    always_comb begin
        w_lo = r_s1_lv ? signed'(w_lim_rd[2*jps_pkg::ANGLE_W-1:jps_pkg::ANGLE_W])
                       : jps_pkg::ANGLE_MIN;
        w_up = r_s1_lv ? signed'(w_lim_rd[jps_pkg::ANGLE_W-1:0]) : jps_pkg::ANGLE_MAX;
        w_des = r_s1_des;
        if (w_des < w_lo) begin
            w_des = w_lo;
        end
        if (w_des > w_up) begin
            w_des = w_up;
        end
        w_err = jps_pkg::t_err'(w_des) - jps_pkg::t_err'(r_s1_meas);
        if (r_s1_fwd) begin
            w_prev = r_fwd_err;
        end else if (r_s1_ev) begin
            w_prev = signed'(w_err_rd);
        end else begin
            w_prev = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_v    <= 1'b0;
            r_err_vld <= '0;
            r_lim_vld <= '0;
        end else begin
            if (o_in_ready) begin
                r_s1_v <= w_ctl_acc;
            end
            if (w_s1_adv) begin
                r_err_vld[r_s1_joint] <= 1'b1;
            end
            if (w_ld_acc) begin
                r_lim_vld[i_joint] <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_ctl_acc) begin
            r_s1_joint <= i_joint;
            r_s1_des   <= i_desired_angle;
            r_s1_meas  <= i_measured_angle;
            r_s1_lv    <= r_lim_vld[i_joint];
            r_s1_ev    <= r_err_vld[i_joint];
            r_s1_fwd   <= w_s1_adv && (r_s1_joint == i_joint);
        end
        if (w_s1_adv) begin
            r_fwd_err <= w_err;
        end
    end

    assign o_s1_valid  = r_s1_v;
    assign o_s1.joint  = r_s1_joint;
    assign o_s1.err    = w_err;
    assign o_s1.prev   = w_prev;

endmodule

`default_nettype wire

// File: rtl/core/jps_law.sv
// PD control law: gain products, rounding to Q8.8 and acceleration clamp,
// ending in the output register. Depends on jps_pkg.
`default_nettype none

module jps_law (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_s1_valid,
    input  wire jps_pkg::t_s1_item  i_s1,
    output logic                    o_s2_ready,
    output logic                    o_out_valid,
    input  wire logic               i_out_ready,
    output jps_pkg::t_joint         o_joint_out,
    output jps_pkg::t_accel         o_acceleration
);

    logic               w_s3_ready;
    jps_pkg::t_diff     n_diff;
    jps_pkg::t_pkp      n_p_kp;
    jps_pkg::t_pkd      n_p_kd;
    jps_pkg::t_sum      n_sum;
    jps_pkg::t_quot     n_q;
    jps_pkg::t_accel    n_acc;
    jps_pkg::t_accel    w_min;

    logic               r_s2_v;
    jps_pkg::t_joint    r_s2_joint;
    jps_pkg::t_pkp      r_p_kp;
    jps_pkg::t_pkd      r_p_kd;
    logic               r_s3_v;
    jps_pkg::t_joint    r_s3_joint;
    jps_pkg::t_accel    r_s3_acc;

    assign w_s3_ready = !r_s3_v || i_out_ready;
    assign o_s2_ready = !r_s2_v || w_s3_ready;

    always_comb begin
        n_diff = jps_pkg::t_diff'(i_s1.err) - jps_pkg::t_diff'(i_s1.prev);
        n_p_kp = jps_pkg::t_pkp'(jps_pkg::kp_q8(i_s1.joint)) * jps_pkg::t_pkp'(i_s1.err);
        n_p_kd = jps_pkg::t_pkd'(jps_pkg::kdr_q8(i_s1.joint)) * jps_pkg::t_pkd'(n_diff);
    end

    always_comb begin
        w_min = jps_pkg::acc_min(r_s2_joint);
        n_sum = jps_pkg::t_sum'(r_p_kp) + jps_pkg::t_sum'(r_p_kd) + jps_pkg::ROUND_HALF;
        n_q   = jps_pkg::t_quot'(n_sum >>> jps_pkg::FRAC_SHIFT);
        if (n_q > jps_pkg::t_quot'(jps_pkg::ACC_MAX)) begin
            n_acc = jps_pkg::ACC_MAX;
        end else if (n_q < jps_pkg::t_quot'(w_min)) begin
            n_acc = w_min;
        end else begin
            n_acc = jps_pkg::t_accel'(n_q);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s2_v <= 1'b0;
            r_s3_v <= 1'b0;
        end else begin
            if (o_s2_ready) begin
                r_s2_v <= i_s1_valid;
            end
            if (w_s3_ready) begin
                r_s3_v <= r_s2_v;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_s2_ready && i_s1_valid) begin
            r_s2_joint <= i_s1.joint;
            r_p_kp     <= n_p_kp;
            r_p_kd     <= n_p_kd;
        end
        if (w_s3_ready && r_s2_v) begin
            r_s3_joint <= r_s2_joint;
            r_s3_acc   <= n_acc;
        end
    end

    assign o_out_valid    = r_s3_v;
    assign o_joint_out    = r_s3_joint;
    assign o_acceleration = r_s3_acc;

endmodule

`default_nettype wire

// File: rtl/core/joint_pd_servo_with_limits_unit.sv
// Top level of the per-joint PD servo with position and acceleration limits.
// Depends on jps_pkg, jps_store and jps_law.
//
//  channel | valid        | ready        | payload
//  --------+--------------+--------------+------------------------------------------
//  in      | i_in_valid   | o_in_ready   | i_kind, i_joint, i_desired_angle,
//          |              |              | i_measured_angle, i_limit_lower, i_limit_upper
//  out     | o_out_valid  | i_out_ready  | o_joint_out, o_acceleration
//
// One item per cycle while the output is not stalled; an accepted control item passes through the registered steps
// memory read, then clamp, error and gain multiply, then round and clamp.
// The error write-back of one item forwards to the next item of the same joint.
// Load items and items for a joint out of range are accepted but give no result.
// Reset marks all per-joint entries unwritten (valid bits); no clearing pass.
// A stalled output holds the last stage; earlier stages keep filling bubbles.
`default_nettype none

module joint_pd_servo_with_limits_unit (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_in_valid,
    output logic                   o_in_ready,
    input  wire logic              i_kind,
    input  wire jps_pkg::t_joint   i_joint,
    input  wire jps_pkg::t_angle   i_desired_angle,
    input  wire jps_pkg::t_angle   i_measured_angle,
    input  wire jps_pkg::t_angle   i_limit_lower,
    input  wire jps_pkg::t_angle   i_limit_upper,
    output logic                   o_out_valid,
    input  wire logic              i_out_ready,
    output jps_pkg::t_joint        o_joint_out,
    output jps_pkg::t_accel        o_acceleration
);

    logic               w_s1_valid;
    logic               w_s2_ready;
    jps_pkg::t_s1_item  w_s1;

    jps_store u_store (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_in_valid       (i_in_valid),
        .o_in_ready       (o_in_ready),
        .i_kind           (i_kind),
        .i_joint          (i_joint),
        .i_desired_angle  (i_desired_angle),
        .i_measured_angle (i_measured_angle),
        .i_limit_lower    (i_limit_lower),
        .i_limit_upper    (i_limit_upper),
        .i_s2_ready       (w_s2_ready),
        .o_s1_valid       (w_s1_valid),
        .o_s1             (w_s1)
    );

    jps_law u_law (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_s1_valid     (w_s1_valid),
        .i_s1           (w_s1),
        .o_s2_ready     (w_s2_ready),
        .o_out_valid    (o_out_valid),
        .i_out_ready    (i_out_ready),
        .o_joint_out    (o_joint_out),
        .o_acceleration (o_acceleration)
    );

endmodule

`default_nettype wire

// File: rtl/core/jps_checker.sv
// Port-level checker for the joint PD servo unit, bound to the top level.
// Depends on jps_pkg and joint_pd_servo_with_limits_unit_defines.svh.
`default_nettype none

`include "joint_pd_servo_with_limits_unit_defines.svh"

module jps_checker (
    input wire logic             i_clk,
    input wire logic             i_rst_n,
    input wire logic             o_in_ready,
    input wire logic             o_out_valid,
    input wire logic             i_out_ready,
    input wire jps_pkg::t_joint  o_joint_out,
    input wire jps_pkg::t_accel  o_acceleration
);

    logic                                                   w_joint_ok;
    logic                                                   w_acc_ok;
    logic                                                   w_out_stall;
    logic                                                   w_out_held;
    logic [jps_pkg::JOINT_W+$bits(jps_pkg::t_accel)-1:0]    r_out_word;

    assign w_joint_ok  = o_joint_out < jps_pkg::JOINT_W'(jps_pkg::JOINTS);
    assign w_acc_ok    = (o_acceleration <= jps_pkg::ACC_MAX)
                      && (o_acceleration >= jps_pkg::acc_min(o_joint_out));
    assign w_out_stall = o_out_valid && !i_out_ready;
    assign w_out_held  = o_out_valid && ({o_joint_out, o_acceleration} == r_out_word);

    always_ff @(posedge i_clk) begin
        r_out_word <= {o_joint_out, o_acceleration};
    end

    `JPS_CHECK(a_joint_range, i_clk, i_rst_n, o_out_valid, w_joint_ok, "joint out of range")

    `JPS_CHECK(a_accel_bounds, i_clk, i_rst_n, o_out_valid, w_acc_ok, "acceleration out of bounds")

    `JPS_CHECK(a_ready_when_empty, i_clk, i_rst_n, !o_out_valid, o_in_ready, "stalled while empty")

    `JPS_CHECK_NEXT(a_out_hold, i_clk, i_rst_n, w_out_stall, w_out_held, "stalled item changed")

endmodule

bind joint_pd_servo_with_limits_unit jps_checker u_jps_checker (.*);

`default_nettype wire

// File: dv/joint_pd_servo_with_limits_unit_tb.sv
// Self-checking testbench of joint_pd_servo_with_limits_unit: directed table, then random items
// under three sender/receiver stall patterns, each result checked against its table value or an in-bench PD model.
// Depends on jps_pkg and the RTL of the unit only.
`default_nettype none

module joint_pd_servo_with_limits_unit_tb;
    import jps_pkg::*;

    localparam int CLK_HALF    = 5;
    localparam int CYCLE_LIMIT = 200000;
    localparam int PHASE_ITEMS = 417;
    localparam int ACC_CEIL    = 1280;
    localparam int MAX_REPORTS = 200;

    typedef struct {
        logic   kind;
        t_joint joint;
        t_angle des;
        t_angle meas;
        t_angle lo;
        t_angle hi;
        bit     known;
        t_accel acc;
    } servo_item_t;

    typedef struct {
        t_joint joint;
        t_accel acc;
    } accel_cmd_t;

    logic   clk;
    logic   rst_n;
    logic   in_valid;
    logic   in_kind;
    t_joint in_joint;
    t_angle in_des;
    t_angle in_meas;
    t_angle in_lo;
    t_angle in_hi;
    logic   out_ready;
    logic   o_in_ready;
    logic   o_out_valid;
    t_joint o_joint_out;
    t_accel o_acceleration;

    int kp_gain [JOINTS] = '{768, 768, 768, 768, 768, 7168, 512, 768, 768, 768,
                             768, 768, 7168, 512, 768, 768, 768};
    int kd_rate [JOINTS] = '{38400, 38400, 38400, 42240, 140800, 24320, 57600, 1280, 1280,
                             1280, 38400, 37120, 140800, 24320, 1280, 1280, 1280};
    int acc_floor [JOINTS] = '{-1280, -1280, -1280, -1280, -1280, -1280, -1280, -5120, -5120,
                               -5120, -1280, -1280, -1280, -1280, -5120, -5120, -5120};
    int last_err [JOINTS];
    int lim_lo [JOINTS];
    int lim_hi [JOINTS];

    accel_cmd_t  cmd_queue[$];
    servo_item_t directed[$];

    int send_idle_pct;
    int recv_stall_pct;
    int errors;
    int reports;
    int cycles;
    int cmds_checked;
    int items_sent;
    int loads_sent;
    int ignored_sent;
    int counted;

    joint_pd_servo_with_limits_unit dut (
        .i_clk            (clk),
        .i_rst_n          (rst_n),
        .i_in_valid       (in_valid),
        .o_in_ready       (o_in_ready),
        .i_kind           (in_kind),
        .i_joint          (in_joint),
        .i_desired_angle  (in_des),
        .i_measured_angle (in_meas),
        .i_limit_lower    (in_lo),
        .i_limit_upper    (in_hi),
        .o_out_valid      (o_out_valid),
        .i_out_ready      (out_ready),
        .o_joint_out      (o_joint_out),
        .o_acceleration   (o_acceleration)
    );

    always #CLK_HALF clk = ~clk;

    function automatic servo_item_t row(input logic kind, input int joint, input int des,
                                       input int meas, input int lo, input int hi,
                                       input bit known, input int acc);
        servo_item_t s;
        s.kind  = kind;
        s.joint = t_joint'(joint);
        s.des   = t_angle'(des);
        s.meas  = t_angle'(meas);
        s.lo    = t_angle'(lo);
        s.hi    = t_angle'(hi);
        s.known = known;
        s.acc   = t_accel'(acc);
        return s;
    endfunction

    function automatic void reset_servo_state();
        for (int j = 0; j < JOINTS; j++) begin
            last_err[j] = 0;
            lim_lo[j]   = -32768;
            lim_hi[j]   = 32767;
        end
    endfunction

    function automatic bit servo_step(input servo_item_t s, output t_accel acc);
        int     des;
        int     err;
        longint sum;
        longint q;
        acc = '0;
        if (s.joint >= JOINTS) return 1'b0;
        if (s.kind == KIND_LOAD) begin
            lim_lo[s.joint] = s.lo;
            lim_hi[s.joint] = s.hi;
            return 1'b0;
        end
        des = s.des;
        if (des < lim_lo[s.joint]) des = lim_lo[s.joint];
        if (des > lim_hi[s.joint]) des = lim_hi[s.joint];
        err = des - int'(s.meas);
        sum = longint'(kp_gain[s.joint]) * err
            + longint'(kd_rate[s.joint]) * (err - last_err[s.joint]);
        q = (sum + 2048) >>> 12;
        if (q > ACC_CEIL) q = ACC_CEIL;
        if (q < acc_floor[s.joint]) q = acc_floor[s.joint];
        last_err[s.joint] = err;
        acc = t_accel'(q);
        return 1'b1;
    endfunction

    function automatic servo_item_t random_item();
        servo_item_t s;
        t_angle      tmp;
        int          mode;
        s.known = 1'b0;
        s.acc   = '0;
        s.kind  = ($urandom_range(99) < 12) ? KIND_LOAD : KIND_CTRL;
        s.joint = ($urandom_range(99) < 92) ? t_joint'($urandom_range(JOINTS - 1))
                                            : t_joint'($urandom_range(31, JOINTS));
        s.des   = t_angle'($urandom);
        s.meas  = t_angle'($urandom);
        s.lo    = t_angle'($urandom);
        s.hi    = t_angle'($urandom);
        mode    = $urandom_range(9);
        if (s.kind == KIND_LOAD) begin
            if (mode < 5) begin
                s.lo = ANGLE_MIN;
                s.hi = ANGLE_MAX;
            end else if (mode < 8 && s.lo > s.hi) begin
                tmp  = s.lo;
                s.lo = s.hi;
                s.hi = tmp;
            end
        end else if (mode < 5) begin
            s.des = t_angle'(int'(s.meas) + int'($urandom_range(64)) - 32);
        end else if (mode < 7) begin
            s.meas = t_angle'(int'($urandom_range(4000)) - 2000);
            s.des  = t_angle'(int'(s.meas) + int'($urandom_range(800)) - 400);
        end
        return s;
    endfunction

    task automatic send_item(input servo_item_t s);
        t_accel acc;
        while ($urandom_range(99) < send_idle_pct) begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        in_kind  <= s.kind;
        in_joint <= s.joint;
        in_des   <= s.des;
        in_meas  <= s.meas;
        in_lo    <= s.lo;
        in_hi    <= s.hi;
        do @(negedge clk); while (o_in_ready !== 1'b1);
        if (servo_step(s, acc))
            cmd_queue.push_back('{s.joint, s.known ? s.acc : acc});
        items_sent++;
        if (s.joint >= JOINTS) ignored_sent++;
        else if (s.kind == KIND_LOAD) loads_sent++;
        @(posedge clk);
    endtask

    task automatic drain_cmds();
        in_valid <= 1'b0;
        @(posedge clk);
        while (cmd_queue.size() != 0) @(posedge clk);
    endtask

    function automatic void note_mismatch(input string what, input int expv, input int actv);
        errors++;
        if (reports < MAX_REPORTS)
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, what, expv, actv);
        reports++;
    endfunction

    always @(posedge clk) begin
        out_ready <= ($urandom_range(99) >= recv_stall_pct);
        cycles++;
        if (cycles == CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d commands outstanding", cycles,
                     cmd_queue.size());
            $display("simulation failed");
            $finish;
        end
    end

    always @(negedge clk) begin
        accel_cmd_t exp_cmd;
        if (rst_n && o_out_valid === 1'b1 && out_ready) begin
            if (cmd_queue.size() == 0) begin
                note_mismatch("unexpected command, joint", -1, o_joint_out);
            end else begin
                exp_cmd = cmd_queue.pop_front();
                if (o_joint_out !== exp_cmd.joint)
                    note_mismatch("joint_out", exp_cmd.joint, o_joint_out);
                if (o_acceleration !== exp_cmd.acc)
                    note_mismatch("acceleration", exp_cmd.acc, o_acceleration);
                cmds_checked++;
            end
        end
    end

    initial begin
        clk            = 1'b0;
        rst_n          = 1'b0;
        in_valid       = 1'b0;
        in_kind        = KIND_CTRL;
        in_joint       = '0;
        in_des         = '0;
        in_meas        = '0;
        in_lo          = '0;
        in_hi          = '0;
        out_ready      = 1'b0;
        errors         = 0;
        reports        = 0;
        cycles         = 0;
        cmds_checked   = 0;
        items_sent     = 0;
        loads_sent     = 0;
        ignored_sent   = 0;
        send_idle_pct  = 21;
        recv_stall_pct = 72;
        reset_servo_state();

        directed.push_back(row(KIND_CTRL, 0, 0, 0, 0, 0, 1, 0));
        directed.push_back(row(KIND_CTRL, 5, 32767, -32768, 0, 0, 1, 1280));
        directed.push_back(row(KIND_CTRL, 7, -32768, 32767, 0, 0, 1, -5120));
        directed.push_back(row(KIND_CTRL, 0, -32768, 32767, 0, 0, 1, -1280));
        directed.push_back(row(KIND_CTRL, 16, 32767, -32768, 0, 0, 1, 1280));
        directed.push_back(row(KIND_CTRL, 17, 100, 0, 0, 0, 0, 0));
        directed.push_back(row(KIND_CTRL, 31, -100, 0, 0, 0, 0, 0));
        directed.push_back(row(KIND_LOAD, 17, 0, 0, 5, 6, 0, 0));
        directed.push_back(row(KIND_LOAD, 31, 0, 0, 5, 6, 0, 0));
        directed.push_back(row(KIND_LOAD, 3, 0, 0, -100, 100, 0, 0));
        directed.push_back(row(KIND_CTRL, 3, 32767, 100, 0, 0, 1, 0));
        directed.push_back(row(KIND_CTRL, 3, -32768, -100, 0, 0, 1, 0));
        directed.push_back(row(KIND_LOAD, 4, 0, 0, 1000, -1000, 0, 0));
        directed.push_back(row(KIND_CTRL, 4, 0, -1000, 0, 0, 1, 0));
        directed.push_back(row(KIND_CTRL, 4, 32767, -1000, 0, 0, 1, 0));
        directed.push_back(row(KIND_CTRL, 6, 100, 0, 0, 0, 0, 0));
        directed.push_back(row(KIND_CTRL, 6, 101, 0, 0, 0, 0, 0));
        directed.push_back(row(KIND_CTRL, 6, 100, 0, 0, 0, 0, 0));
        directed.push_back(row(KIND_CTRL, 12, 1, 0, 0, 0, 0, 0));
        directed.push_back(row(KIND_CTRL, 9, -1, 0, 0, 0, 0, 0));
        directed.push_back(row(KIND_LOAD, 3, 0, 0, 32767, 32767, 0, 0));
        directed.push_back(row(KIND_CTRL, 3, -32768, 32767, 0, 0, 1, 0));
        directed.push_back(row(KIND_LOAD, 3, 0, 0, -32768, -32768, 0, 0));
        directed.push_back(row(KIND_CTRL, 3, 32767, -32768, 0, 0, 1, 0));

        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (directed[i]) send_item(directed[i]);

        for (int phase = 0; phase < 3; phase++) begin
            if (phase == 1) begin
                send_idle_pct  = 72;
                recv_stall_pct = 21;
            end else if (phase == 2) begin
                send_idle_pct  = 0;
                recv_stall_pct = 0;
            end
            counted = 0;
            while (counted < PHASE_ITEMS) begin
                servo_item_t s;
                s = random_item();
                send_item(s);
                counted++;
            end
            drain_cmds();
        end

        repeat (10) @(posedge clk);
        $display("sent %0d items (%0d limit loads, %0d out-of-range joints) under three stall",
                 items_sent, loads_sent, ignored_sent);
        $display("patterns; checked %0d acceleration commands, %0d errors", cmds_checked, errors);
        if (errors == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule

`default_nettype wire

// File: files.f
+incdir+rtl/core
rtl/core/jps_pkg.sv
rtl/core/jps_ram.sv
rtl/core/jps_store.sv
rtl/core/jps_law.sv
rtl/core/joint_pd_servo_with_limits_unit.sv
rtl/core/jps_checker.sv
dv/joint_pd_servo_with_limits_unit_tb.sv
